FILE: design/ps2mpt_pkg.sv
// Package for the PS/2 mouse packet tracker: widths, field codes and the
// item, state and result types shared by the core and the top level.
// Depends on nothing.
package ps2mpt_pkg;

    // Cursor coordinate width; the screen bound may reach 2**POS_BITS.
    localparam int POS_BITS = 12;
    localparam int BND_W    = POS_BITS + 1;
    localparam int CFG_W    = 13;
    localparam int ABS_W    = 16;

    localparam logic [BND_W-1:0] BOUND_MAX = {1'b1, {POS_BITS{1'b0}}};
    localparam logic [ABS_W-1:0] ABS_FULL  = 16'hFFFF;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1280;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd720;

    // Item kinds carried on tuser.
    localparam logic ACT_RAW = 1'b0;
    localparam logic ACT_ABS = 1'b1;

    // Position of the next raw byte within a packet.
    localparam logic [1:0] BYTE_FIRST  = 2'd0;
    localparam logic [1:0] BYTE_SECOND = 2'd1;
    localparam logic [1:0] BYTE_THIRD  = 2'd2;

    // Bits of the first packet byte.
    localparam int          SYNC_BIT  = 3;
    localparam int          XSIGN_BIT = 4;
    localparam int          YSIGN_BIT = 5;
    localparam logic [7:0]  OVF_MASK  = 8'hC0;

    typedef struct packed {
        logic                action;
        logic [7:0]          data_byte;
        logic [ABS_W-1:0]    abs_x_in;
        logic [ABS_W-1:0]    abs_y_in;
        logic [2:0]          abs_buttons_in;
    } item_t;

    typedef struct packed {
        logic [7:0]          first_byte;
        logic [7:0]          second_byte;
        logic [1:0]          byte_position;
        logic [POS_BITS-1:0] cursor_x;
        logic [POS_BITS-1:0] cursor_y;
        logic [2:0]          last_buttons;
    } state_t;

    typedef struct packed {
        logic signed [8:0]   delta_x;
        logic signed [9:0]   delta_y;
        logic [POS_BITS-1:0] pos_x;
        logic [POS_BITS-1:0] pos_y;
        logic [2:0]          button_levels;
        logic [2:0]          pressed_edges;
        logic [2:0]          released_edges;
    } result_t;

endpackage

FILE: design/ps2mpt_core.sv
// Combinational update of the PS/2 mouse packet tracker for one item:
// packet assembly, validity check, cursor update, absolute scaling.
// Depends on ps2mpt_pkg.
module ps2mpt_core
    import ps2mpt_pkg::*;
(
    input  item_t            item,
    input  state_t           state,
    input  logic [CFG_W-1:0] screen_width,
    input  logic [CFG_W-1:0] screen_height,
    output state_t           state_next,
    output result_t          result,
    output logic             result_valid
);

    // A bound of zero acts as one; a bound above the coordinate range is limited to it.
    function automatic logic [BND_W-1:0] eff_bound(input logic [CFG_W-1:0] raw);
        logic [CFG_W+BND_W-1:0] raw_wide;
        raw_wide = (CFG_W+BND_W)'(raw);
        if (raw == '0)
            return BND_W'(1);
        else if (raw_wide > (CFG_W+BND_W)'(BOUND_MAX))
            return BOUND_MAX;
        else
            return BND_W'(raw);
    endfunction

    // floor(a * bound / 65535), clamped to bound - 1. The quotient is first
    // estimated as the product shifted down by 16; the remainder then equals
    // the low half plus that estimate and needs at most one correction.
    function automatic logic [POS_BITS-1:0] scale_abs(input logic [ABS_W-1:0] a,
                                                      input logic [BND_W-1:0] bound);
        logic [ABS_W+BND_W-1:0] prod;
        logic [BND_W-1:0]       q0;
        logic [ABS_W:0]         rem;
        logic [BND_W-1:0]       q;
        prod = (ABS_W+BND_W)'(a) * (ABS_W+BND_W)'(bound);
        q0   = prod[ABS_W +: BND_W];
        rem  = {1'b0, prod[ABS_W-1:0]} + (ABS_W+1)'(q0);
        q    = (rem >= {1'b0, ABS_FULL}) ? q0 + 1'b1 : q0;
        if (q >= bound)
            q = bound - 1'b1;
        return q[POS_BITS-1:0];
    endfunction

    // Cursor plus signed movement, clamped to 0..bound-1.
    function automatic logic [POS_BITS-1:0] clamp_pos(input logic [POS_BITS-1:0] cur,
                                                      input logic signed [9:0] delta,
                                                      input logic [BND_W-1:0] bound);
        logic signed [POS_BITS+1:0] sum;
        sum = $signed({2'b00, cur}) + $signed({{(POS_BITS-8){delta[9]}}, delta});
        if (sum[POS_BITS+1])
            return '0;
        else if (sum[POS_BITS:0] >= bound)
            return POS_BITS'(bound - 1'b1);
        else
            return sum[POS_BITS-1:0];
    endfunction

    logic [BND_W-1:0]  bound_x;
    logic [BND_W-1:0]  bound_y;
    logic              packet_good;
    logic signed [8:0] dx;
    logic signed [8:0] dy_raw;
    logic signed [9:0] dy;
    logic [2:0]        buttons;

    assign bound_x     = eff_bound(screen_width);
    assign bound_y     = eff_bound(screen_height);
    assign packet_good = state.first_byte[SYNC_BIT] && ((state.first_byte & OVF_MASK) == '0);
    assign dx          = {state.first_byte[XSIGN_BIT], state.second_byte};
    assign dy_raw      = {state.first_byte[YSIGN_BIT], item.data_byte};
    assign dy          = 10'sd0 - {dy_raw[8], dy_raw};

    always_comb
    begin
        state_next   = state;
        result_valid = 1'b0;
        buttons      = item.abs_buttons_in;
        result       = '0;

        if (item.action == ACT_ABS)
        begin
            state_next.cursor_x = scale_abs(item.abs_x_in, bound_x);
            state_next.cursor_y = scale_abs(item.abs_y_in, bound_y);
            result_valid        = 1'b1;
        end
        else
        begin
            case (state.byte_position)
                BYTE_FIRST:
                begin
                    state_next.first_byte    = item.data_byte;
                    state_next.byte_position = BYTE_SECOND;
                end
                BYTE_SECOND:
                begin
                    state_next.second_byte   = item.data_byte;
                    state_next.byte_position = BYTE_THIRD;
                end
                default:
                begin
                    state_next.byte_position = BYTE_FIRST;
                    if (packet_good)
                    begin
                        buttons             = state.first_byte[2:0];
                        state_next.cursor_x = clamp_pos(state.cursor_x, {dx[8], dx}, bound_x);
                        state_next.cursor_y = clamp_pos(state.cursor_y, dy, bound_y);
                        result.delta_x      = dx;
                        result.delta_y      = dy;
                        result_valid        = 1'b1;
                    end
                end
            endcase
        end

        if (result_valid)
        begin
            state_next.last_buttons = buttons;
            result.pos_x            = state_next.cursor_x;
            result.pos_y            = state_next.cursor_y;
            result.button_levels    = buttons;
            result.pressed_edges    = buttons & ~state.last_buttons;
            result.released_edges   = state.last_buttons & ~buttons;
        end
    end

endmodule

FILE: design/ps2_mouse_packet_tracker_top.sv
// Top level of the PS/2 mouse packet tracker: stream ports, APB register
// file, input and result registers around the update core.
// Depends on ps2mpt_pkg and ps2mpt_core.
//
// Usage:
// The slave stream (s_tvalid, s_tready, s_tdata, s_tuser) carries one item per
// transfer: either a raw byte from the mouse port (s_tuser low) or an absolute
// position report (s_tuser high). Every third raw byte completes a packet; a
// good packet, and every absolute report, produces one result transfer on the
// master stream (m_tvalid, m_tready, m_tdata). Bad packets and the first two
// bytes of a packet produce nothing.
// An accepted item is held in an input register while the core computes; the
// result is then loaded into the output register, which drives m_tvalid. One
// item is accepted every cycle while the output register is free or being
// emptied; the update loop through the cursor and packet registers is
// combinational in the core.
// When the receiver stalls, the pending result stays in the output register
// and one more item waits in the input register; s_tready then drops until
// m_tready returns.
// Reset clears the cursor, packet assembly and button history and loads the screen
// bounds with 1280 by 720. The user writes the bounds over the APB port (width at
// 0x0, height at 0x4) only while the stream is idle; the block does not enforce it.
module ps2_mouse_packet_tracker_top
    import ps2mpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata fields from bit 0: data_byte[7:0], abs_x_in[23:8], abs_y_in[39:24],
    // abs_buttons_in[42:40], zero fill [47:43].
    input  logic [47:0] s_tdata,
    // s_tuser fields from bit 0: action.
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields from bit 0: delta_x[8:0], delta_y[18:9], pos_x[30:19],
    // pos_y[42:31], button_levels[45:43], pressed_edges[48:46],
    // released_edges[51:49], zero fill [55:52].
    output logic [55:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Register index taken from the word address.
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    logic             in_valid_reg;
    logic             in_valid_next;
    item_t            item_reg;
    item_t            item_next;

    state_t           state_reg;
    state_t           state_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    result_t          out_next;

    result_t          core_result;
    logic             core_result_valid;
    logic             fire;
    logic             cfg_write;

    // Configuration port. Writes complete in the access phase; reads return
    // the stored bound.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_SCREEN_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, width_reg};
            REG_SCREEN_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, height_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_SCREEN_WIDTH)
                width_reg <= pwdata[CFG_W-1:0];
            else
                height_reg <= pwdata[CFG_W-1:0];
        end
    end

    // The item in the input register is processed whenever the output
    // register is free or being emptied in the same cycle.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    ps2mpt_core u_core (
        .item          (item_reg),
        .state         (state_reg),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .state_next    (state_next),
        .result        (core_result),
        .result_valid  (core_result_valid)
    );

    always_comb
    begin
        item_next.action         = s_tuser;
        item_next.data_byte      = s_tdata[7:0];
        item_next.abs_x_in       = s_tdata[23:8];
        item_next.abs_y_in       = s_tdata[39:24];
        item_next.abs_buttons_in = s_tdata[42:40];

        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (fire && core_result_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = core_result;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tready)
            item_reg <= item_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_reg.released_edges,
                       out_reg.pressed_edges,
                       out_reg.button_levels,
                       out_reg.pos_y,
                       out_reg.pos_x,
                       out_reg.delta_y,
                       out_reg.delta_x};

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ps2_mouse_packet_tracker_top: drives PS/2 bytes and absolute
// reports on the input stream, predicts every cursor report and checks the output stream.
// Depends on ps2mpt_pkg and the RTL of the tracker; needs no other file.
module tb_top;
    import ps2mpt_pkg::*;

    // Cycles without any stream transfer before the run is declared hung. The slowest
    // correct run never comes near this: stalls and gaps are geometric with p = 0.8.
    localparam int HANG_LIMIT = 5000;
    // Cycles that pass after the last expected report before a register write or the end.
    localparam int SETTLE_CYCLES = 6;

    // Register byte addresses on the APB port.
    localparam logic [2:0] ADDR_WIDTH  = 3'h0;
    localparam logic [2:0] ADDR_HEIGHT = 3'h4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata fields from bit 0: data_byte, abs_x_in, abs_y_in, abs_buttons_in, zero fill.
    logic [47:0] s_tdata = '0;
    // s_tuser fields from bit 0: action.
    logic        s_tuser = 1'b0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata fields from bit 0: delta_x, delta_y, pos_x, pos_y, button_levels,
    // pressed_edges, released_edges, zero fill.
    logic [55:0] m_tdata;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the tracker: configuration, packet assembly and cursor.
    logic [CFG_W-1:0]    bound_w_reg;
    logic [CFG_W-1:0]    bound_h_reg;
    logic [7:0]          pkt_byte0;
    logic [7:0]          pkt_byte1;
    logic [1:0]          pkt_index;
    logic [POS_BITS-1:0] cursor_col;
    logic [POS_BITS-1:0] cursor_row;
    logic [2:0]          held_buttons;

    result_t pending_reports[$];
    int      fail_count = 0;
    int      raw_sent = 0;
    int      items_sent = 0;
    int      tx_idle_pct = 0;
    int      rx_stall_pct = 0;
    int      hang_count = 0;

    ps2_mouse_packet_tracker_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // A zero bound behaves as one, and anything above the coordinate range is cut to it.
    function automatic int effective_bound(input logic [CFG_W-1:0] b);
        if (b == '0)
            return 1;
        if (b > BOUND_MAX)
            return int'(BOUND_MAX);
        return int'(b);
    endfunction

    function automatic logic [POS_BITS-1:0] clamp_pos(input int v, input int bound);
        int c;
        c = v;
        if (c < 0)
            c = 0;
        else if (c >= bound)
            c = bound - 1;
        return c[POS_BITS-1:0];
    endfunction

    // Full scale would land exactly on the bound, so the result is pulled back to bound-1.
    function automatic logic [POS_BITS-1:0] scale_abs(input logic [ABS_W-1:0] a, input int bound);
        longint s;
        s = (longint'(a) * longint'(bound)) / longint'(ABS_FULL);
        if (s >= longint'(bound))
            s = longint'(bound - 1);
        return s[POS_BITS-1:0];
    endfunction

    // Advances the shadow state by one item; returns 1 when the item produces a report.
    function automatic bit predict_report(input item_t it, output result_t rpt);
        int         w;
        int         h;
        int         dx;
        int         dy;
        logic [2:0] btn;
        w = effective_bound(bound_w_reg);
        h = effective_bound(bound_h_reg);
        dx = 0;
        dy = 0;
        rpt = '0;
        if (it.action == ACT_ABS)
        begin
            // An absolute report leaves any partial packet in place.
            cursor_col = scale_abs(it.abs_x_in, w);
            cursor_row = scale_abs(it.abs_y_in, h);
            btn = it.abs_buttons_in;
        end
        else
        begin
            if (pkt_index == BYTE_FIRST)
            begin
                pkt_byte0 = it.data_byte;
                pkt_index = BYTE_SECOND;
                return 1'b0;
            end
            if (pkt_index == BYTE_SECOND)
            begin
                pkt_byte1 = it.data_byte;
                pkt_index = BYTE_THIRD;
                return 1'b0;
            end
            pkt_index = BYTE_FIRST;
            // Packets without the sync bit or with an overflow flag are dropped silently.
            if (!pkt_byte0[SYNC_BIT] || (pkt_byte0 & OVF_MASK) != '0)
                return 1'b0;
            dx = int'(pkt_byte1) - (pkt_byte0[XSIGN_BIT] ? 256 : 0);
            dy = -(int'(it.data_byte) - (pkt_byte0[YSIGN_BIT] ? 256 : 0));
            btn = pkt_byte0[2:0];
            cursor_col = clamp_pos(int'(cursor_col) + dx, w);
            cursor_row = clamp_pos(int'(cursor_row) + dy, h);
        end
        rpt.delta_x = dx[8:0];
        rpt.delta_y = dy[9:0];
        rpt.pos_x = cursor_col;
        rpt.pos_y = cursor_row;
        rpt.button_levels = btn;
        rpt.pressed_edges = btn & ~held_buttons;
        rpt.released_edges = held_buttons & ~btn;
        held_buttons = btn;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Both streams are sampled at the rising edge, before the edge's own updates land.
    // Output is checked before the input is predicted; a report always trails its item.
    always @(posedge clk)
    begin
        result_t exp_r;
        result_t got;
        item_t   it;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.delta_x = m_tdata[8:0];
                got.delta_y = m_tdata[18:9];
                got.pos_x = m_tdata[30:19];
                got.pos_y = m_tdata[42:31];
                got.button_levels = m_tdata[45:43];
                got.pressed_edges = m_tdata[48:46];
                got.released_edges = m_tdata[51:49];
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: unexpected report, expected none, actual %0h",
                             $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_reports.pop_front();
                    report_field("delta_x", 16'(exp_r.delta_x), 16'(got.delta_x));
                    report_field("delta_y", 16'(exp_r.delta_y), 16'(got.delta_y));
                    report_field("pos_x", 16'(exp_r.pos_x), 16'(got.pos_x));
                    report_field("pos_y", 16'(exp_r.pos_y), 16'(got.pos_y));
                    report_field("button_levels", 16'(exp_r.button_levels),
                                 16'(got.button_levels));
                    report_field("pressed_edges", 16'(exp_r.pressed_edges),
                                 16'(got.pressed_edges));
                    report_field("released_edges", 16'(exp_r.released_edges),
                                 16'(got.released_edges));
                    report_field("zero fill", 16'h0, 16'(m_tdata[55:52]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                it.action = s_tuser;
                it.data_byte = s_tdata[7:0];
                it.abs_x_in = s_tdata[23:8];
                it.abs_y_in = s_tdata[39:24];
                it.abs_buttons_in = s_tdata[42:40];
                if (predict_report(it, exp_r))
                    pending_reports.push_back(exp_r);
            end
        end
    end

    // The receiver drops tready at random for the share of cycles the phase asks.
    always @(posedge clk)
        m_tready <= (int'($urandom_range(99)) >= rx_stall_pct);

    // Any transfer on either stream counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                hang_count <= 0;
            else if (hang_count >= HANG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                hang_count <= hang_count + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Unused fields carry random values; the tracker must ignore them.
    function automatic item_t make_raw(input logic [7:0] b);
        item_t it;
        it.action = ACT_RAW;
        it.data_byte = b;
        it.abs_x_in = ABS_W'($urandom);
        it.abs_y_in = ABS_W'($urandom);
        it.abs_buttons_in = 3'($urandom);
        return it;
    endfunction

    function automatic item_t make_abs(input logic [ABS_W-1:0] x, input logic [ABS_W-1:0] y,
                                       input logic [2:0] btn);
        item_t it;
        it.action = ACT_ABS;
        it.data_byte = 8'($urandom);
        it.abs_x_in = x;
        it.abs_y_in = y;
        it.abs_buttons_in = btn;
        return it;
    endfunction

    // Presents one item and returns at the edge that takes it. The sender then may go
    // idle for a geometric number of cycles; tvalid is only lowered when it really idles.
    task automatic send_item(input item_t it);
        s_tvalid <= 1'b1;
        s_tuser <= it.action;
        s_tdata <= {5'b0, it.abs_buttons_in, it.abs_y_in, it.abs_x_in, it.data_byte};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (it.action == ACT_RAW)
            raw_sent++;
        if (int'($urandom_range(99)) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (int'($urandom_range(99)) < tx_idle_pct);
        end
    endtask

    task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2);
        send_item(make_raw(b0));
        send_item(make_raw(b1));
        send_item(make_raw(b2));
    endtask

    // Lets every outstanding report arrive, then a few cycles more so that a trailing
    // byte that produces nothing has left the pipeline too.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register. Only called while idle.
    task automatic write_bound(input logic [2:0] addr, input logic [CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {{(32-CFG_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_WIDTH)
            bound_w_reg = value;
        else
            bound_h_reg = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {{(32-CFG_W){1'b0}}, value})
        begin
            $display("%0t: register %0h read-back mismatch, expected %0h, actual %0h",
                     $time, addr, value, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_bounds(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_for_drain();
        write_bound(ADDR_WIDTH, w);
        write_bound(ADDR_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Good packets at the delta extremes, dropped packets, and absolute reports,
    // one of them arriving in the middle of a packet.
    task automatic test_packet_decode();
        send_packet(8'h09, 8'h10, 8'h05);       // left button, small move, y clamps at 0
        send_packet(8'h0A, 8'hFF, 8'h00);       // dx = +255, right button
        send_packet(8'h3F, 8'h00, 8'h00);       // dx = -256, dy = +256, all buttons
        send_packet(8'h18, 8'hFF, 8'hFF);       // dx = -1, dy = -255
        send_packet(8'h2C, 8'h01, 8'hFF);       // dy sign with byte 0xFF gives +1, middle
        send_packet(8'h07, 8'h55, 8'hAA);       // sync bit clear: dropped
        send_packet(8'h48, 8'h12, 8'h34);       // x overflow: dropped
        send_packet(8'h88, 8'h12, 8'h34);       // y overflow: dropped
        send_item(make_raw(8'h09));
        send_item(make_abs(16'h8000, 16'h8000, 3'b010));  // packet stays half assembled
        send_item(make_raw(8'h20));
        send_item(make_raw(8'hE0));
        send_item(make_abs(16'h0000, 16'h0000, 3'b000));
        send_item(make_abs(16'hFFFF, 16'hFFFF, 3'b111));
    endtask

    // Bound extremes: zero, one, exactly the coordinate range, and above it, plus a
    // cursor that is left outside a bound that shrinks under it.
    task automatic test_screen_bounds();
        set_bounds(13'd4096, 13'd4096);
        send_item(make_abs(16'hFFFF, 16'hFFFF, 3'b001));
        set_bounds(13'd100, 13'd50);
        send_packet(8'h08, 8'h00, 8'h00);       // no motion, clamps to 99, 49
        set_bounds(13'd0, 13'd0);
        send_item(make_abs(16'hFFFF, 16'h7FFF, 3'b100));
        send_packet(8'h08, 8'h7F, 8'h80);
        set_bounds(13'd8191, 13'd4097);
        send_item(make_abs(16'hFFFF, 16'hFFFF, 3'b000));
        send_packet(8'h08, 8'h01, 8'h00);       // x already at the top of the range
        set_bounds(13'd1, 13'd4095);
        send_item(make_abs(16'h1234, 16'hFFFF, 3'b011));
        send_packet(8'h38, 8'h80, 8'h80);
    endtask

    function automatic logic [ABS_W-1:0] pick_abs();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? ABS_FULL : '0;
        return ABS_W'($urandom);
    endfunction

    // Mostly well-formed packets with random content, mixed with absolute reports,
    // broken packets and stray bytes that throw the packet alignment off.
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int         stop_at;
        int         kind;
        logic [7:0] b0;
        stop_at = items_sent + count;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        while (items_sent < stop_at)
        begin
            kind = int'($urandom_range(99));
            if (kind < 12)
                send_item(make_abs(pick_abs(), pick_abs(), 3'($urandom)));
            else if (kind < 20)
                send_item(make_raw(8'($urandom)));
            else
            begin
                // Stray bytes first so the packet starts on a packet boundary.
                while (raw_sent % 3 != 0)
                    send_item(make_raw(8'($urandom)));
                b0 = (8'($urandom) & 8'h37) | 8'h08;
                if ($urandom_range(99) < 15)
                    b0 = $urandom_range(1) ? (b0 & 8'hF7) : (b0 | (8'($urandom) & OVF_MASK));
                send_item(make_raw(b0));
                if ($urandom_range(99) < 8)
                    send_item(make_abs(pick_abs(), pick_abs(), 3'($urandom)));
                send_item(make_raw(8'($urandom)));
                send_item(make_raw(8'($urandom)));
            end
        end
        tx_idle_pct = 0;
        rx_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        bound_w_reg = WIDTH_RESET;
        bound_h_reg = HEIGHT_RESET;
        pkt_byte0 = '0;
        pkt_byte1 = '0;
        pkt_index = BYTE_FIRST;
        cursor_col = '0;
        cursor_row = '0;
        held_buttons = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_packet_decode();
        test_screen_bounds();

        set_bounds(WIDTH_RESET, HEIGHT_RESET);
        test_random_traffic(0, 0, 250);
        set_bounds(CFG_W'($urandom_range(4096, 1)), CFG_W'($urandom_range(4096, 1)));
        test_random_traffic(80, 0, 250);
        set_bounds(CFG_W'($urandom_range(16, 1)), CFG_W'($urandom_range(16, 1)));
        test_random_traffic(0, 80, 250);
        set_bounds(13'd8191, 13'd0);
        test_random_traffic(32, 32, 250);

        wait_for_drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
